[rtl/core/pmo_pkg.sv]
package pmo_pkg;

  localparam int COORD_W   = 32;
  localparam int RADIUS_W  = 32;
  localparam int IDX_W     = 10;
  // edge and length magnitudes stay below 2^(COORD_W+1)
  localparam int EDGE_W    = COORD_W + 1;
  localparam int LEN_W     = COORD_W + 1;
  // largest magnitude is |r| * |L1*e2 - L2*e1| < 2^(2*COORD_W+33)
  localparam int MAG_W     = 2 * COORD_W + 34;
  localparam int MUL_W     = (EDGE_W > RADIUS_W) ? EDGE_W : RADIUS_W;
  localparam int CAP_SHIFT = 62;
  localparam int OFF_W     = 64;
  localparam int DEFAULT_MAX_VERTICES = 1024;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic [IDX_W-1:0]          vertex_index;
    logic                      solved;
    logic                      polygon_done;
  } result_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef enum logic [3:0] {
    ST_X1SQ = 4'd0,
    ST_Y1SQ = 4'd1,
    ST_L1   = 4'd2,
    ST_X2SQ = 4'd3,
    ST_Y2SQ = 4'd4,
    ST_L2   = 4'd5,
    ST_CR1  = 4'd6,
    ST_CR2  = 4'd7,
    ST_NX1  = 4'd8,
    ST_NX2  = 4'd9,
    ST_NY1  = 4'd10,
    ST_NY2  = 4'd11,
    ST_RX   = 4'd12,
    ST_QX   = 4'd13,
    ST_RY   = 4'd14,
    ST_QY   = 4'd15
  } step_t;

endpackage

[rtl/core/pmo_arith.sv]
module pmo_arith (
  input  logic                       clk,
  input  logic                       rst,
  input  pmo_pkg::arith_req_t        req,
  input  logic [pmo_pkg::MAG_W-1:0]  opa,
  input  logic [pmo_pkg::MAG_W-1:0]  opb,
  output logic                       done,
  output logic [pmo_pkg::MAG_W-1:0]  result
);
  import pmo_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic             busy;
  arith_op_t        op;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] acc, sa, sb, rem;
  logic [MAG_W:0]   sub_a, sub_b;
  logic [MAG_W+1:0] diff;
  logic             ge;
  logic [MAG_W-1:0] sum;

  // one trial subtract per cycle, shared by divide and square root
  always_comb begin
    case (op)
      OP_DIV: begin
        sub_a = {rem, sa[MAG_W-1]};
        sub_b = {1'b0, sb};
      end
      OP_SQRT: begin
        sub_a = {rem[MAG_W-2:0], sa[MAG_W-1:MAG_W-2]};
        sub_b = {1'b0, acc[MAG_W-3:0], 2'b01};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = !diff[MAG_W+1];
    sum  = acc + sa;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        case (req.op)
          OP_MUL:  cnt <= CNT_W'(MUL_W - 1);
          OP_SQRT: cnt <= CNT_W'(LEN_W - 1);
          default: cnt <= CNT_W'(MAG_W - 1);
        endcase
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      acc <= '0;
      rem <= '0;
      sb  <= opb;
      // align the radicand so its top bit pair comes first
      sa  <= (req.op == OP_SQRT) ? (opa << (MAG_W - 2 * LEN_W)) : opa;
    end else if (busy) begin
      case (op)
        OP_MUL: begin
          if (sb[0]) acc <= sum;
          sa <= sa << 1;
          sb <= sb >> 1;
        end
        OP_DIV: begin
          rem <= ge ? diff[MAG_W-1:0] : sub_a[MAG_W-1:0];
          acc <= {acc[MAG_W-2:0], ge};
          sa  <= sa << 1;
        end
        OP_SQRT: begin
          rem <= ge ? diff[MAG_W-1:0] : sub_a[MAG_W-1:0];
          acc <= {acc[MAG_W-2:0], ge};
          sa  <= sa << 2;
        end
        default: ;
      endcase
    end
  end

  assign result = acc;

endmodule

[rtl/core/pmo_miter.sv]
module pmo_miter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [pmo_pkg::COORD_W-1:0]  p_x,
  input  logic signed [pmo_pkg::COORD_W-1:0]  p_y,
  input  logic signed [pmo_pkg::COORD_W-1:0]  c_x,
  input  logic signed [pmo_pkg::COORD_W-1:0]  c_y,
  input  logic signed [pmo_pkg::COORD_W-1:0]  n_x,
  input  logic signed [pmo_pkg::COORD_W-1:0]  n_y,
  input  logic signed [pmo_pkg::RADIUS_W-1:0] radius,
  output logic                                done,
  output logic signed [pmo_pkg::COORD_W-1:0]  res_x,
  output logic signed [pmo_pkg::COORD_W-1:0]  res_y,
  output logic                                res_solved
);
  import pmo_pkg::*;

  typedef enum logic [3:0] {
    E_IDLE  = 4'b0001,
    E_ISSUE = 4'b0010,
    E_WAIT  = 4'b0100,
    E_FINAL = 4'b1000
  } eng_state_t;

  eng_state_t state;
  step_t      step;

  logic [EDGE_W-1:0]   ex1m, ey1m, ex2m, ey2m;
  logic                sx1, sy1, sx2, sy2;
  logic [COORD_W-1:0]  cx, cy;
  logic [RADIUS_W-1:0] rm;
  logic                rneg;
  logic [MAG_W-1:0]    tmp, qx, qy;
  logic [LEN_W-1:0]    l1, l2;
  logic [MAG_W:0]      pv, dv, nx, ny;

  arith_req_t       req;
  logic [MAG_W-1:0] opa, opb, ares;
  logic             adone;

  logic signed [EDGE_W-1:0] e1x, e1y, e2x, e2y;
  logic [RADIUS_W-1:0]      rabs;
  logic                     degen;

  function automatic logic [EDGE_W-1:0] edge_mag(input logic signed [EDGE_W-1:0] v);
    edge_mag = v[EDGE_W-1] ? EDGE_W'(-v) : EDGE_W'(v);
  endfunction

  function automatic logic [MAG_W:0] to_signed(input logic neg, input logic [MAG_W-1:0] m);
    logic [MAG_W:0] ext;
    ext = {1'b0, m};
    to_signed = neg ? -ext : ext;
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W:0] v);
    logic [MAG_W:0] t;
    t = v[MAG_W] ? -v : v;
    mag_of = t[MAG_W-1:0];
  endfunction

  // cap the offset, add it to the vertex and saturate to the coordinate range
  function automatic logic [COORD_W-1:0] place(input logic [COORD_W-1:0] cv,
                                                input logic [MAG_W-1:0] q,
                                                input logic neg);
    logic [MAG_W-1:0]        capm;
    logic [OFF_W-1:0]        capv, off;
    logic signed [OFF_W:0]   s, hi, lo;
    capm = MAG_W'(1) << CAP_SHIFT;
    capv = (q > capm) ? capm[OFF_W-1:0] : q[OFF_W-1:0];
    off  = neg ? -capv : capv;
    hi   = {{(OFF_W + 2 - COORD_W){1'b0}}, {(COORD_W - 1){1'b1}}};
    lo   = ~hi;
    s    = $signed({{(OFF_W + 1 - COORD_W){cv[COORD_W-1]}}, cv})
         + $signed({off[OFF_W-1], off});
    if (s > hi) place = hi[COORD_W-1:0];
    else if (s < lo) place = lo[COORD_W-1:0];
    else place = s[COORD_W-1:0];
  endfunction

  assign e1x  = {c_x[COORD_W-1], c_x} - {p_x[COORD_W-1], p_x};
  assign e1y  = {c_y[COORD_W-1], c_y} - {p_y[COORD_W-1], p_y};
  assign e2x  = {n_x[COORD_W-1], n_x} - {c_x[COORD_W-1], c_x};
  assign e2y  = {n_y[COORD_W-1], n_y} - {c_y[COORD_W-1], c_y};
  assign rabs = radius[RADIUS_W-1] ? RADIUS_W'(-radius) : RADIUS_W'(radius);

  always_comb begin
    req.start = (state == E_ISSUE);
    req.op    = OP_MUL;
    opa       = '0;
    opb       = '0;
    case (step)
      ST_X1SQ: begin opa = MAG_W'(ex1m); opb = MAG_W'(ex1m); end
      ST_Y1SQ: begin opa = MAG_W'(ey1m); opb = MAG_W'(ey1m); end
      ST_L1:   begin req.op = OP_SQRT; opa = tmp; end
      ST_X2SQ: begin opa = MAG_W'(ex2m); opb = MAG_W'(ex2m); end
      ST_Y2SQ: begin opa = MAG_W'(ey2m); opb = MAG_W'(ey2m); end
      ST_L2:   begin req.op = OP_SQRT; opa = tmp; end
      ST_CR1:  begin opa = MAG_W'(ex1m); opb = MAG_W'(ey2m); end
      ST_CR2:  begin opa = MAG_W'(ey1m); opb = MAG_W'(ex2m); end
      ST_NX1:  begin opa = MAG_W'(l1); opb = MAG_W'(ex2m); end
      ST_NX2:  begin opa = MAG_W'(l2); opb = MAG_W'(ex1m); end
      ST_NY1:  begin opa = MAG_W'(l1); opb = MAG_W'(ey2m); end
      ST_NY2:  begin opa = MAG_W'(l2); opb = MAG_W'(ey1m); end
      ST_RX:   begin opa = mag_of(nx); opb = MAG_W'(rm); end
      ST_QX:   begin req.op = OP_DIV; opa = tmp; opb = mag_of(dv); end
      ST_RY:   begin opa = mag_of(ny); opb = MAG_W'(rm); end
      ST_QY:   begin req.op = OP_DIV; opa = tmp; opb = mag_of(dv); end
      default: ;
    endcase
  end

  pmo_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .done   (adone),
    .result (ares)
  );

  assign degen = (l1 == '0) || (l2 == '0) || (rm == '0) || (dv == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      step  <= ST_X1SQ;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        E_IDLE: begin
          if (start) begin
            step  <= ST_X1SQ;
            state <= E_ISSUE;
          end
        end
        E_ISSUE: state <= E_WAIT;
        E_WAIT: begin
          if (adone) begin
            if (step == ST_QY) begin
              state <= E_FINAL;
            end else begin
              step  <= step_t'(4'(step) + 4'd1);
              state <= E_ISSUE;
            end
          end
        end
        E_FINAL: begin
          done  <= 1'b1;
          state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_IDLE && start) begin
      ex1m <= edge_mag(e1x);
      ey1m <= edge_mag(e1y);
      ex2m <= edge_mag(e2x);
      ey2m <= edge_mag(e2y);
      sx1  <= e1x[EDGE_W-1];
      sy1  <= e1y[EDGE_W-1];
      sx2  <= e2x[EDGE_W-1];
      sy2  <= e2y[EDGE_W-1];
      cx   <= c_x;
      cy   <= c_y;
      rm   <= rabs;
      rneg <= radius[RADIUS_W-1];
    end
    if (state == E_WAIT && adone) begin
      case (step)
        ST_X1SQ, ST_X2SQ, ST_RX, ST_RY: tmp <= ares;
        ST_Y1SQ, ST_Y2SQ:               tmp <= tmp + ares;
        ST_L1:  l1 <= ares[LEN_W-1:0];
        ST_L2:  l2 <= ares[LEN_W-1:0];
        ST_CR1: pv <= to_signed(sx1 ^ sy2, ares);
        ST_CR2: dv <= pv - to_signed(sy1 ^ sx2, ares);
        ST_NX1: pv <= to_signed(sx2, ares);
        ST_NX2: nx <= pv - to_signed(sx1, ares);
        ST_NY1: pv <= to_signed(sy2, ares);
        ST_NY2: ny <= pv - to_signed(sy1, ares);
        ST_QX:  qx <= ares;
        ST_QY:  qy <= ares;
        default: ;
      endcase
    end
    if (state == E_FINAL) begin
      res_solved <= !degen;
      res_x <= degen ? '0 : place(cx, qx, rneg ^ nx[MAG_W] ^ dv[MAG_W]);
      res_y <= degen ? '0 : place(cy, qy, rneg ^ ny[MAG_W] ^ dv[MAG_W]);
    end
  end

endmodule

[rtl/core/polygon_miter_offset_top.sv]
// Polygon miter offset: vertices of a closed polygon stream in as signed
// Q15.16 words, the final one flagged by last_vertex. Each vertex is pushed
// out by the configured radius along the left normals of both its edges and the
// mitered corner is returned with its index; vertices 1..n-2 come out as
// their successor arrives, vertex n-1 as it arrives flagged last, then
// vertex 0 closes the polygon with polygon_done set. Parallel or zero-length
// edges, or a zero radius, give solved=0 and a zero point. For each result
// a single bit-serial unit runs twelve multiplies, two square roots and
// two divides in turn; an input word yields zero to three results, and one
// with results stalls the input from acceptance until its last result
// reaches the output register of one finished word.
module polygon_miter_offset_top #(
  parameter int MAX_VERTICES = pmo_pkg::DEFAULT_MAX_VERTICES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pmo_pkg::vertex_t                    in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pmo_pkg::result_t                    out_word,
  input  logic                                cfg_wr_en,
  input  logic [pmo_pkg::RADIUS_W-1:0]        cfg_wr_data
);
  import pmo_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES);

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_START = 4'b0010,
    T_CALC  = 4'b0100,
    T_PUT   = 4'b1000
  } top_state_t;

  top_state_t state;

  logic signed [RADIUS_W-1:0] radius;
  logic signed [COORD_W-1:0]  first_x, first_y, second_x, second_y;
  logic signed [COORD_W-1:0]  older_x, older_y, newest_x, newest_y;
  logic signed [COORD_W-1:0]  a_px, a_py, a_cx, a_cy;
  logic [CNT_W-1:0]           count, c_saved;
  logic                       need_a, need_b, need_c, multi;

  logic                       accept, slot_free;
  logic signed [COORD_W-1:0]  sp_x, sp_y, sc_x, sc_y, sn_x, sn_y;
  logic [CNT_W-1:0]           sel_idx;
  logic [CNT_W+IDX_W-1:0]     idx_ext;
  logic                       sel_done;

  logic                       eng_done, eng_solved;
  logic signed [COORD_W-1:0]  eng_x, eng_y;

  assign in_stall  = (state != T_IDLE);
  assign accept    = in_valid && (state == T_IDLE);
  assign slot_free = !out_valid || !out_stall;

  // pending corners go in order: middle vertex, then last, then vertex 0
  always_comb begin
    if (need_a) begin
      sp_x = a_px;     sp_y = a_py;
      sc_x = a_cx;     sc_y = a_cy;
      sn_x = newest_x; sn_y = newest_y;
      sel_idx  = c_saved - CNT_W'(1);
      sel_done = 1'b0;
    end else if (need_b) begin
      sp_x = older_x;  sp_y = older_y;
      sc_x = newest_x; sc_y = newest_y;
      sn_x = first_x;  sn_y = first_y;
      sel_idx  = c_saved;
      sel_done = 1'b0;
    end else begin
      sp_x = newest_x; sp_y = newest_y;
      sc_x = first_x;  sc_y = first_y;
      sn_x = multi ? second_x : first_x;
      sn_y = multi ? second_y : first_y;
      sel_idx  = '0;
      sel_done = 1'b1;
    end
    idx_ext = {{IDX_W{1'b0}}, sel_idx};
  end

  pmo_miter u_miter (
    .clk        (clk),
    .rst        (rst),
    .start      (state == T_START),
    .p_x        (sp_x),
    .p_y        (sp_y),
    .c_x        (sc_x),
    .c_y        (sc_y),
    .n_x        (sn_x),
    .n_y        (sn_y),
    .radius     (radius),
    .done       (eng_done),
    .res_x      (eng_x),
    .res_y      (eng_y),
    .res_solved (eng_solved)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      radius    <= '0;
      count     <= '0;
      need_a    <= 1'b0;
      need_b    <= 1'b0;
      need_c    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) radius <= cfg_wr_data;
      if (out_valid && !out_stall && state != T_PUT) out_valid <= 1'b0;
      case (state)
        T_IDLE: begin
          if (accept) begin
            need_a <= (count > CNT_W'(1));
            need_b <= in_word.last_vertex && (count != '0);
            need_c <= in_word.last_vertex;
            if (in_word.last_vertex || count == CNT_W'(MAX_VERTICES - 1)) count <= '0;
            else count <= count + CNT_W'(1);
            if (count > CNT_W'(1) || in_word.last_vertex) state <= T_START;
          end
        end
        T_START: state <= T_CALC;
        T_CALC: begin
          if (eng_done) state <= T_PUT;
        end
        T_PUT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (need_a) need_a <= 1'b0;
            else if (need_b) need_b <= 1'b0;
            else need_c <= 1'b0;
            // more than one pending corner means another pass
            if ((need_a && (need_b || need_c)) || (need_b && need_c)) state <= T_START;
            else state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_saved <= count;
      multi   <= (count != '0);
      if (count == '0) begin
        first_x  <= in_word.vertex_x;
        first_y  <= in_word.vertex_y;
        older_x  <= in_word.vertex_x;
        older_y  <= in_word.vertex_y;
        newest_x <= in_word.vertex_x;
        newest_y <= in_word.vertex_y;
      end else if (count == CNT_W'(1)) begin
        second_x <= in_word.vertex_x;
        second_y <= in_word.vertex_y;
        older_x  <= first_x;
        older_y  <= first_y;
        newest_x <= in_word.vertex_x;
        newest_y <= in_word.vertex_y;
      end else begin
        a_px     <= older_x;
        a_py     <= older_y;
        a_cx     <= newest_x;
        a_cy     <= newest_y;
        older_x  <= newest_x;
        older_y  <= newest_y;
        newest_x <= in_word.vertex_x;
        newest_y <= in_word.vertex_y;
      end
    end
    if (state == T_PUT && slot_free) begin
      out_word.out_x        <= eng_x;
      out_word.out_y        <= eng_y;
      out_word.vertex_index <= idx_ext[IDX_W-1:0];
      out_word.solved       <= eng_solved;
      out_word.polygon_done <= sel_done;
    end
  end

endmodule
